// ===== hdl/hwpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Hann-windowed power envelope block.
// No dependencies; used by every other file in hdl/.
package hwpe_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned SQ_W         = 31;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned PROD_W       = 33;
  localparam int unsigned ACC_W        = 40;
  localparam int unsigned PERIOD_W     = 11;
  localparam int unsigned PEAK_W       = 15;
  localparam int unsigned MS_W         = 32;
  localparam int unsigned OUT_W        = 48;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd512;

  localparam logic [63:0] PI_Q30  = 64'd3373256577;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_ACC_DRAIN,
    S_SHIFT,
    S_SHIFT_DRAIN,
    S_PUSH
  } state_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_MOV,
    OP_CLR
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } uop_t;

endpackage

// ===== hdl/hwpe_rom.sv =====
`timescale 1ns / 1ps
// Hann window coefficient ROM, Q0.32, built at elaboration, registered read.
// Depends on hwpe_pkg.
module hwpe_rom #(
  parameter int unsigned WINDOW_POINTS = 1024,
  parameter int unsigned AW            = 10
) (
  input  logic                             clk,
  input  logic [AW-1:0]                    addr,
  output logic [hwpe_pkg::WORD_W-1:0]      data
);

  typedef logic [hwpe_pkg::WORD_W-1:0] rom_t [WINDOW_POINTS];

  function automatic logic [hwpe_pkg::WORD_W-1:0] hann_word(input int unsigned i);
    logic [63:0] m;
    logic [63:0] phi;
    logic [63:0] p2;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] w;
    m   = (i <= WINDOW_POINTS - i) ? 64'(i) : 64'(WINDOW_POINTS - i);
    phi = (hwpe_pkg::PI_Q30 * m) / WINDOW_POINTS;
    p2  = (phi * phi) >> 30;
    r   = hwpe_pkg::ONE_Q30;
    for (int k = 5; k >= 1; k--) begin
      x = (p2 * r) >> 30;
      case (k)
        5:       t = x / 110;
        4:       t = x / 72;
        3:       t = x / 42;
        2:       t = x / 20;
        default: t = x / 6;
      endcase
      r = (t >= hwpe_pkg::ONE_Q30) ? 64'd0 : hwpe_pkg::ONE_Q30 - t;
    end
    s = (phi * r) >> 30;
    if (s > hwpe_pkg::ONE_Q30) begin
      s = hwpe_pkg::ONE_Q30;
    end
    w = ((s * s) >> 27) / WINDOW_POINTS;
    return w[hwpe_pkg::WORD_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t tab;
    for (int unsigned i = 0; i < WINDOW_POINTS; i++) begin
      tab[i] = hann_word(i);
    end
    return tab;
  endfunction

  localparam rom_t HANN = build_rom();

  always_ff @(posedge clk) begin
    data <= HANN[addr];
  end

endmodule

// ===== hdl/hwpe_slots.sv =====
`timescale 1ns / 1ps
// Overlap accumulator store: one write port, one registered read port,
// per-entry valid bits so unwritten entries read as zero. Depends on hwpe_pkg.
module hwpe_slots #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [AW-1:0]                   rd_addr,
  output logic [hwpe_pkg::ACC_W-1:0]      rd_data,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [hwpe_pkg::ACC_W-1:0]      wr_data
);

  logic [hwpe_pkg::ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [hwpe_pkg::ACC_W-1:0] rd_word;
  logic                       rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_word : '0;

endmodule

// ===== hdl/hwpe_mac.sv =====
`timescale 1ns / 1ps
// Shared weighted-square multiply and saturating accumulate unit.
// Registers the product, then forms the slot write-back. Depends on hwpe_pkg.
module hwpe_mac #(
  parameter int unsigned AW = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hwpe_pkg::uop_t                   in_u,
  input  logic [AW-1:0]                    in_addr,
  input  logic [hwpe_pkg::SQ_W-1:0]        sq,
  input  logic [hwpe_pkg::WORD_W-1:0]      weight,
  input  logic [hwpe_pkg::ACC_W-1:0]       sum,
  output hwpe_pkg::uop_t                   out_u,
  output logic [AW-1:0]                    out_addr,
  output logic [hwpe_pkg::ACC_W-1:0]       out_data
);

  localparam int unsigned FULL_W = hwpe_pkg::SQ_W + hwpe_pkg::WORD_W;

  logic [FULL_W-1:0]            prod_full;
  logic [hwpe_pkg::PROD_W-1:0]  prod;
  logic [hwpe_pkg::ACC_W-1:0]   sum_r;
  logic [hwpe_pkg::ACC_W:0]     sum_ext;

  assign prod_full = FULL_W'(sq) * FULL_W'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_u.valid <= 1'b0;
      out_u.op    <= hwpe_pkg::OP_CLR;
    end else begin
      out_u <= in_u;
    end
  end

  always_ff @(posedge clk) begin
    out_addr <= in_addr;
    prod     <= prod_full[FULL_W-1:30];
    sum_r    <= sum;
  end

  assign sum_ext = {1'b0, sum_r} + (hwpe_pkg::ACC_W + 1)'(prod);

  always_comb begin
    case (out_u.op)
      hwpe_pkg::OP_ACC: out_data = sum_ext[hwpe_pkg::ACC_W] ? '1
                                                             : sum_ext[hwpe_pkg::ACC_W-1:0];
      hwpe_pkg::OP_MOV: out_data = sum_r;
      default:          out_data = '0;
    endcase
  end

endmodule

// ===== hdl/hann_window_power_envelope_peak_top.sv =====
`timescale 1ns / 1ps
// Top level: sequencer, sample/peak/phase registers and output register.
// Depends on hwpe_pkg, hwpe_rom, hwpe_slots, hwpe_mac.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[15:0] sample
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[31:0] mean_square,
//                                               [46:32] peak_level, [47] zero
//  cfg       in   cfg_we                        cfg_wdata[10:0] output_period
//
// Each sample updates one slot per window open at the current phase, one slot
// update per cycle through the single multiply unit; no slot is cleared when
// all MAX_OVERLAP windows are open.
// A sample that emits then shifts K slots (K < MAX_OVERLAP) down through the
// slot store, and waits for the output register if it is still full.
// Reset is synchronous; slot valid bits clear at once, no clearing pass.
// s_axis_tready is high only between samples; m_axis stalls hold the result.
module hann_window_power_envelope_peak_top #(
  parameter int unsigned WINDOW_POINTS = 1024,
  parameter int unsigned MAX_OVERLAP   = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hwpe_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [15:0] sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [hwpe_pkg::OUT_W-1:0]          m_axis_tdata,   // [31:0] mean_square,
                                                              // [46:32] peak_level
  input  logic                                cfg_we,
  input  logic [hwpe_pkg::PERIOD_W-1:0]       cfg_wdata       // output_period
);

  localparam int unsigned AW     = $clog2(WINDOW_POINTS);
  localparam int unsigned IW     = AW + 1;
  localparam int unsigned SAW    = $clog2(MAX_OVERLAP);
  localparam int unsigned JW     = $clog2(MAX_OVERLAP + 1);
  localparam int unsigned PER_LO = WINDOW_POINTS / MAX_OVERLAP + 1;

  hwpe_pkg::state_t state;
  hwpe_pkg::state_t state_next;

  logic [hwpe_pkg::PERIOD_W-1:0] period_cfg;
  logic [31:0]                   cfg_ext;
  logic [IW-1:0]                 per_eff;
  logic [IW-1:0]                 per_r;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 idx_next;
  logic [JW-1:0]                 j;
  logic [JW-1:0]                 j_next;
  logic [JW-1:0]                 j_inc;
  logic [AW-1:0]                 phase;
  logic                          emit_r;
  logic [hwpe_pkg::SQ_W-1:0]     sq_r;
  logic signed [31:0]            sq_full;
  logic [hwpe_pkg::PEAK_W-1:0]   running_peak;
  logic [hwpe_pkg::PEAK_W-1:0]   peak_new;
  logic [hwpe_pkg::PEAK_W-1:0]   pk_pend;
  logic [hwpe_pkg::MS_W-1:0]     ms_r;
  logic                          accept;
  logic                          push;
  logic                          j_room;
  logic                          acc_go;
  logic                          sh_go;
  logic                          pipe_idle;

  hwpe_pkg::uop_t                iss;
  logic [SAW-1:0]                iss_ra;
  logic [SAW-1:0]                iss_wa;
  hwpe_pkg::uop_t                u1;
  logic [SAW-1:0]                wa1;
  hwpe_pkg::uop_t                wr_u;
  logic [SAW-1:0]                wr_addr;
  logic [hwpe_pkg::ACC_W-1:0]    wr_data;
  logic [hwpe_pkg::ACC_W-1:0]    rd_data;
  logic [hwpe_pkg::WORD_W-1:0]   rom_data;

  assign cfg_ext = {{(32 - hwpe_pkg::PERIOD_W){1'b0}}, period_cfg};
  assign per_eff = (cfg_ext < 32'(PER_LO))        ? IW'(PER_LO) :
                   (cfg_ext > 32'(WINDOW_POINTS)) ? IW'(WINDOW_POINTS) :
                                                    IW'(cfg_ext);

  assign sq_full  = $signed(s_axis_tdata) * $signed(s_axis_tdata);
  assign peak_new = (!s_axis_tdata[hwpe_pkg::SAMPLE_W-1] &&
                     (s_axis_tdata[hwpe_pkg::PEAK_W-1:0] > running_peak))
                    ? s_axis_tdata[hwpe_pkg::PEAK_W-1:0] : running_peak;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign j_inc     = j + JW'(1);
  assign j_room    = j < JW'(MAX_OVERLAP);
  assign acc_go    = (idx < IW'(WINDOW_POINTS)) && j_room;
  assign sh_go     = (idx < IW'(WINDOW_POINTS)) && (j_inc < JW'(MAX_OVERLAP));
  assign pipe_idle = !u1.valid && !wr_u.valid;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    j_next        = j;
    iss.valid     = 1'b0;
    iss.op        = hwpe_pkg::OP_CLR;
    iss_ra        = j[SAW-1:0];
    iss_wa        = j[SAW-1:0];
    s_axis_tready = 1'b0;
    push          = 1'b0;
    case (state)
      hwpe_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = hwpe_pkg::S_ACC;
          idx_next   = {1'b0, phase};
          j_next     = '0;
        end
      end
      hwpe_pkg::S_ACC: begin
        if (acc_go) begin
          iss.valid = 1'b1;
          iss.op    = hwpe_pkg::OP_ACC;
          idx_next  = idx + per_r;
          j_next    = j_inc;
        end else begin
          iss.valid  = j_room;
          state_next = hwpe_pkg::S_ACC_DRAIN;
        end
      end
      hwpe_pkg::S_ACC_DRAIN: begin
        if (pipe_idle) begin
          if (emit_r) begin
            state_next = hwpe_pkg::S_SHIFT;
            idx_next   = per_r;
            j_next     = '0;
          end else begin
            state_next = hwpe_pkg::S_IDLE;
          end
        end
      end
      hwpe_pkg::S_SHIFT: begin
        if (sh_go) begin
          iss.valid = 1'b1;
          iss.op    = hwpe_pkg::OP_MOV;
          iss_ra    = j_inc[SAW-1:0];
          idx_next  = idx + per_r;
          j_next    = j_inc;
        end else begin
          iss.valid  = 1'b1;
          state_next = hwpe_pkg::S_SHIFT_DRAIN;
        end
      end
      hwpe_pkg::S_SHIFT_DRAIN: begin
        if (pipe_idle) begin
          state_next = hwpe_pkg::S_PUSH;
        end
      end
      hwpe_pkg::S_PUSH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          push       = 1'b1;
          state_next = hwpe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hwpe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hwpe_pkg::S_IDLE;
      period_cfg    <= hwpe_pkg::PERIOD_RESET;
      phase         <= '0;
      running_peak  <= '0;
      emit_r        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      u1.valid      <= 1'b0;
      u1.op         <= hwpe_pkg::OP_CLR;
    end else begin
      state <= state_next;
      u1    <= iss;
      if (cfg_we) begin
        period_cfg <= cfg_wdata;
      end
      if (accept) begin
        emit_r <= (phase == '0);
        if (phase == '0) begin
          phase        <= AW'(per_eff - IW'(1));
          running_peak <= '0;
        end else begin
          phase        <= phase - AW'(1);
          running_peak <= peak_new;
        end
      end
      if (push) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    j   <= j_next;
    wa1 <= iss_wa;
    if (accept) begin
      per_r   <= per_eff;
      sq_r    <= sq_full[hwpe_pkg::SQ_W-1:0];
      pk_pend <= peak_new;
    end
    if (wr_u.valid && (wr_u.op == hwpe_pkg::OP_ACC) && (wr_addr == '0)) begin
      ms_r <= (|wr_data[hwpe_pkg::ACC_W-1:hwpe_pkg::MS_W]) ? '1
                                                           : wr_data[hwpe_pkg::MS_W-1:0];
    end
    if (push) begin
      m_axis_tdata <= {1'b0, pk_pend, ms_r};
    end
  end

  hwpe_rom #(
    .WINDOW_POINTS (WINDOW_POINTS),
    .AW            (AW)
  ) u_rom (
    .clk  (clk),
    .addr (idx[AW-1:0]),
    .data (rom_data)
  );

  hwpe_slots #(
    .DEPTH (MAX_OVERLAP),
    .AW    (SAW)
  ) u_slots (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (iss_ra),
    .rd_data (rd_data),
    .wr_en   (wr_u.valid),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  hwpe_mac #(
    .AW (SAW)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_u     (u1),
    .in_addr  (wa1),
    .sq       (sq_r),
    .weight   (rom_data),
    .sum      (rd_data),
    .out_u    (wr_u),
    .out_addr (wr_addr),
    .out_data (wr_data)
  );

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!u1.valid && !wr_u.valid))
    else $error("slot pipeline busy while accepting a sample");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == hwpe_pkg::S_ACC))
    else $error("accepted sample did not start accumulation");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_u.valid |-> (32'(wr_addr) < MAX_OVERLAP))
    else $error("slot write beyond last slot");

endmodule
